>>> sv/stable_priority_queue_unit_defines.svh
// assertion macros for the stable priority queue unit
// expects clk_i and rst_ni in the scope of each use
`ifndef STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/spq_pkg.sv
// shared types, constants and helpers of the stable priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  row;
    logic [7:0]  seat;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       idx_dec;
    logic       idx_inc;
    logic       rd_en;
    logic       rd_minus1;
    logic       wr_en;
    logic       wr_new;
    logic       wr_minus1;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_status;
    logic [1:0] status_code;
    logic       latch_head;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_remove;
    logic empty;
    logic full;
    logic idx_zero;
    logic idx_is_one;
    logic last_move;
    logic key_gt;
    logic out_busy;
  } sts_t;

  // occupancy field is seven bits, wraps modulo 128
  function automatic logic [6:0] occ_of(logic [CW-1:0] c);
    logic [CW+6:0] w;
    w = (CW + 7)'(c);
    return w[6:0];
  endfunction

endpackage

>>> sv/stable_priority_queue_unit.sv
// top level of the stable priority queue: controller plus datapath
// depends on spq_pkg, spq_ctrl, spq_datapath and the defines header
`timescale 1ns / 1ps
//
//  channel  handshake              fields
//  -------  ---------------------  ---------------------------------------------
//  in       in_valid_i/in_ready_o  opcode_i priority_req_i row_i seat_i
//  out      out_valid_o/out_ready_i status_o out_priority_o out_row_o out_seat_o
//                                   occupancy_o
//
//  one item at a time; in_ready_o is high only while the controller is idle
//  insert: walks down from the tail, moving each larger entry up one slot with a read
//    then a write through the single entry ram, and puts the new entry in the hole
//  remove: latches the head and moves every later entry down; full or empty skip the walk
//  reset clears the count and the output valid; ram contents need no clearing
//  a stalled result waits in the output register; the next item is accepted
//    meanwhile and held at its end until the output frees

module stable_priority_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [15:0] priority_req_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  seat_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_priority_o,
  output logic [7:0]  out_row_o,
  output logic [7:0]  out_seat_o,
  output logic [6:0]  occupancy_o
);
  import spq_pkg::*;

  `include "stable_priority_queue_unit_defines.svh"

  // command and status between the two halves
  cmd_t cmd;
  sts_t sts;

  // result classes and the occupancy of a full queue, for the checks below
  logic       res_empty;
  logic       res_full;
  logic [6:0] full_occ;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // entries live in the ram sorted ascending, equal keys in arrival order
  spq_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .priority_req_i(priority_req_i),
    .row_i         (row_i),
    .seat_i        (seat_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .out_priority_o(out_priority_o),
    .out_row_o     (out_row_o),
    .out_seat_o    (out_seat_o),
    .occupancy_o   (occupancy_o)
  );

  assign res_empty = out_valid_o && (status_o == ST_EMPTY);
  assign res_full  = out_valid_o && (status_o == ST_FULL);
  assign full_occ  = occ_of(CW'(CAPACITY));

  // only one item in the controller at a time
  `SPQ_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item accepted")
  // a remove that found nothing reports an empty queue
  `SPQ_ASSERT(a_empty_occ, res_empty |-> occupancy_o == 7'd0, "empty status with entries")
  // a dropped insert reports a full queue
  `SPQ_ASSERT(a_full_occ, res_full |-> occupancy_o == full_occ, "full status below capacity")
  // the result stays low while reset is held
  `SPQ_ASSERT_ALWAYS(a_rst_out, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

>>> sv/spq_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/spq_datapath.sv
// datapath: entry ram, count and index registers, item and result registers
// depends on spq_pkg and spq_ram
`timescale 1ns / 1ps

module spq_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::cmd_t cmd_i,
  output spq_pkg::sts_t sts_o,
  input  logic          opcode_i,
  input  logic [15:0]   priority_req_i,
  input  logic [7:0]    row_i,
  input  logic [7:0]    seat_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [1:0]    status_o,
  output logic [15:0]   out_priority_o,
  output logic [7:0]    out_row_o,
  output logic [7:0]    out_seat_o,
  output logic [6:0]    occupancy_o
);
  import spq_pkg::*;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          op_q;
  entry_t        item_q;
  logic [1:0]    res_status_q;
  entry_t        res_entry_q;
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  entry_t        out_entry_q;
  logic [6:0]    out_occ_q;

  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_p1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic [EW-1:0] rd_raw;

  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign rd_addr = cmd_i.rd_minus1 ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wr_addr = cmd_i.wr_minus1 ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wr_data = cmd_i.wr_new ? item_q : rd_data;
  assign rd_data = entry_t'(rd_raw);

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_raw)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.capture) begin
      idx_d = (opcode_i == OP_REMOVE) ? '0 : count_q;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_m1;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.capture) begin
      op_q         <= opcode_i;
      item_q       <= '{key: priority_req_i, row: row_i, seat: seat_i};
      res_status_q <= ST_OK;
      res_entry_q  <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status_code;
      end
      if (cmd_i.latch_head) begin
        res_entry_q <= rd_data;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
      out_occ_q    <= occ_of(count_q);
    end
  end

  assign sts_o.op_remove  = (op_q == OP_REMOVE);
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CW'(CAPACITY));
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.idx_is_one = (idx_q == CW'(1));
  assign sts_o.last_move  = (idx_p1 == count_q);
  assign sts_o.key_gt     = (rd_data.key > item_q.key);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_priority_o = out_entry_q.key;
  assign out_row_o      = out_entry_q.row;
  assign out_seat_o     = out_entry_q.seat;
  assign occupancy_o    = out_occ_q;

endmodule

>>> sv/spq_ctrl.sv
// controller: sequences insert and remove walks over the entry ram
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_INS_RD  = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_INS_PUT = 3'd4;
  localparam logic [2:0] S_REM_RD  = 3'd5;
  localparam logic [2:0] S_REM_MV  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts_i.op_remove) begin
          if (sts_i.full) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_FULL;
            state_d           = S_DONE;
          end else if (sts_i.empty) begin
            state_d = S_INS_PUT;
          end else begin
            state_d = S_INS_RD;
          end
        end else begin
          if (sts_i.empty) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = ST_EMPTY;
            state_d           = S_DONE;
          end else begin
            state_d = S_REM_RD;
          end
        end
      end
      // look at the entry just below the hole
      S_INS_RD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_minus1 = 1'b1;
        state_d         = S_INS_CMP;
      end
      S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.key_gt) begin
          cmd_o.idx_dec = 1'b1;
          state_d       = sts_i.idx_is_one ? S_INS_PUT : S_INS_RD;
        end else begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_new  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_DONE;
      end
      S_REM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_REM_MV;
      end
      S_REM_MV: begin
        if (sts_i.idx_zero) begin
          cmd_o.latch_head = 1'b1;
        end else begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_minus1 = 1'b1;
        end
        if (sts_i.last_move) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_REM_RD;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> tb/testbench.sv
// self-checking testbench for the stable priority queue unit
// drives directed and random insert/remove items and checks each result against a sorted-queue model
// depends on spq_pkg and stable_priority_queue_unit
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int ITEM_TARGET    = 850;
  localparam int MAX_IDLE       = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  // leave room for one full-depth walk
  localparam int TAIL_CYCLES    = 4 * CAPACITY + 50;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] key;
    logic [7:0]  row;
    logic [7:0]  seat;
    logic [6:0]  occupancy;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = OP_INSERT;
  logic [15:0] priority_req_i = '0;
  logic [7:0]  row_i = '0;
  logic [7:0]  seat_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] out_priority_o;
  logic [7:0]  out_row_o;
  logic [7:0]  out_seat_o;
  logic [6:0]  occupancy_o;

  // model of the queue contents, ascending by key, ties in arrival order
  entry_t sorted_entries[$];
  reply_t awaited_replies[$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  empty_removes = 0;
  int  full_inserts = 0;
  int  peak_occupancy = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  stable_priority_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .priority_req_i (priority_req_i),
    .row_i          (row_i),
    .seat_i         (seat_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_row_o      (out_row_o),
    .out_seat_o     (out_seat_o),
    .occupancy_o    (occupancy_o)
  );

  always #2 clk_i = ~clk_i;

  // apply one accepted item to the model and queue up the result it must give
  task automatic predict_reply(input logic op, input logic [15:0] key,
                               input logic [7:0] row, input logic [7:0] seat);
    reply_t rep;
    entry_t ent;
    int     pos;
    rep = '0;
    if (op == OP_INSERT) begin
      if (sorted_entries.size() >= CAPACITY) begin
        rep.status = ST_FULL;
        full_inserts++;
      end else begin
        // slot goes after every stored key that is less or equal
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].key <= key) pos++;
        ent.key  = key;
        ent.row  = row;
        ent.seat = seat;
        sorted_entries.insert(pos, ent);
        rep.status = ST_OK;
      end
    end else if (sorted_entries.size() == 0) begin
      rep.status = ST_EMPTY;
      empty_removes++;
    end else begin
      ent = sorted_entries.pop_front();
      rep.status = ST_OK;
      rep.key    = ent.key;
      rep.row    = ent.row;
      rep.seat   = ent.seat;
    end
    rep.occupancy = 7'(sorted_entries.size());
    if (sorted_entries.size() > peak_occupancy) peak_occupancy = sorted_entries.size();
    awaited_replies.push_back(rep);
  endtask

  // offer one item after a random gap when idling is on; valid stays up through back-to-back items
  task automatic offer_item(input logic op, input logic [15:0] key,
                            input logic [7:0] row, input logic [7:0] seat);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    priority_req_i <= key;
    row_i          <= row;
    seat_i         <= seat;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_reply(op, key, row, seat);
  endtask

  task automatic offer_remove();
    offer_item(OP_REMOVE, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // hold the input side until every outstanding result has come back
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // result side: random stall per item, compare each accepted result in order
  initial begin : result_checker
    reply_t want;
    int     stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      results_checked++;
      if (awaited_replies.size() == 0) begin
        $error("result with no item outstanding: status %0d occupancy %0d",
               status_o, occupancy_o);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status", want.status, status_o);
        check_field("out_priority", want.key, out_priority_o);
        check_field("out_row", want.row, out_row_o);
        check_field("out_seat", want.seat, out_seat_o);
        check_field("occupancy", want.occupancy, occupancy_o);
      end
    end
  end

  // a run with no handshake for too long is hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stable_priority_queue_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // removes on an empty queue, field bits ignored
  task automatic test_empty_remove();
    offer_item(OP_REMOVE, 16'hFFFF, 8'hFF, 8'hFF);
    offer_item(OP_REMOVE, 16'h0000, 8'h00, 8'h00);
  endtask

  // key and payload extremes come back out in key order
  task automatic test_field_extremes();
    offer_item(OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF);
    offer_item(OP_INSERT, 16'h0000, 8'h00, 8'h00);
    offer_item(OP_INSERT, 16'h8000, 8'hAA, 8'h55);
    offer_item(OP_INSERT, 16'h7FFF, 8'h55, 8'hAA);
    repeat (4) offer_remove();
  endtask

  // equal keys leave in arrival order, smaller and larger keys around them
  task automatic test_equal_keys();
    offer_item(OP_INSERT, 16'h1234, 8'd1, 8'h41);
    offer_item(OP_INSERT, 16'h1234, 8'd2, 8'h42);
    offer_item(OP_INSERT, 16'h2000, 8'd9, 8'h5A);
    offer_item(OP_INSERT, 16'h1234, 8'd3, 8'h43);
    offer_item(OP_INSERT, 16'h0100, 8'd7, 8'h47);
    offer_item(OP_INSERT, 16'h1234, 8'd4, 8'h44);
    offer_remove();
    offer_item(OP_INSERT, 16'h1234, 8'd5, 8'h45);
    repeat (6) offer_remove();
    offer_remove();
  endtask

  // fill to capacity back to back, overflow, then drain past empty
  task automatic test_full_queue();
    int fill;
    idle_on = 1'b0;
    fill = CAPACITY - sorted_entries.size();
    repeat (fill) offer_item(OP_INSERT, 16'($urandom_range(0, 15)), 8'($urandom),
                             8'($urandom));
    idle_on = 1'b1;
    offer_item(OP_INSERT, 16'h0000, 8'h00, 8'h00);
    offer_item(OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF);
    offer_item(OP_INSERT, 16'h0007, 8'h12, 8'h34);
    repeat (CAPACITY + 1) offer_remove();
  endtask

  // segments with their own insert bias, key spread and idling
  task automatic test_random_mix();
    int          seg_len;
    int          insert_pct;
    int          key_mode;
    int          pause_at;
    bit          paused;
    logic        op;
    logic [15:0] key;
    paused   = 1'b0;
    pause_at = items_sent + $urandom_range(150, 400);
    while (items_sent < ITEM_TARGET) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 25;
        1:       insert_pct = 50;
        default: insert_pct = 80;
      endcase
      key_mode = $urandom_range(0, 2);
      idle_on  = ($urandom_range(0, 3) != 0);
      repeat (seg_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        case (key_mode)
          0: key = 16'($urandom);
          // narrow range, lots of ties
          1: key = 16'($urandom_range(0, 7));
          default: begin
            case ($urandom_range(0, 2))
              0:       key = 16'h0000;
              1:       key = 16'hFFFF;
              default: key = 16'($urandom);
            endcase
          end
        endcase
        if (op == OP_INSERT) offer_item(OP_INSERT, key, 8'($urandom), 8'($urandom));
        else offer_remove();
      end
      if (!paused && items_sent >= pause_at) begin
        wait_until_drained();
        paused = 1'b1;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_remove();
    test_field_extremes();
    test_equal_keys();
    test_full_queue();
    test_random_mix();

    wait_until_drained();
    // give a stray late result time to show up
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d items sent, %0d results checked, peak occupancy %0d of %0d",
             items_sent, results_checked, peak_occupancy, CAPACITY);
    $display("%0d removes on empty queue, %0d inserts dropped as full",
             empty_removes, full_inserts);
    if (errors == 0) begin
      $display("stable_priority_queue_unit verification clean");
    end else begin
      $display("stable_priority_queue_unit verification failed");
    end
    $finish;
  end

endmodule
